[rtl/core/ksca_pkg.sv]
// ----------------------------------------------------------------------------
// ksca_pkg: shared types and constants of the keyed sum/count aggregate unit
// Table geometry, field widths, command and result records, status bundle.
// ----------------------------------------------------------------------------
package ksca_pkg;

    // table geometry
    localparam int NUM_KEYS = 4096;
    localparam int IDX_W    = $clog2(NUM_KEYS);

    // field widths
    localparam int KEY_W   = 12;
    localparam int LIMIT_W = 13;
    localparam int WORD_W  = 32;

    // key limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

    // queue depths
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

    // item operations
    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    // classified command from front to back
    typedef struct packed {
        op_t                      op;
        logic                     ok;
        logic [IDX_W-1:0]         idx;
        logic signed [WORD_W-1:0] value;
        logic                     dropped;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic signed [WORD_W-1:0] sum;
        logic [WORD_W-1:0]        count;
        logic                     present;
        logic                     dropped;
    } res_t;

    // back end status seen by the front
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

[rtl/core/ksca_front.sv]
// ----------------------------------------------------------------------------
// ksca_front: input side of the aggregate unit
// Holds key_limit and the sticky drop flag, range-checks keys, queues commands.
// ----------------------------------------------------------------------------
module ksca_front
    import ksca_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [LIMIT_W-1:0]       cfg_data,
    // input items
    input  logic                     push,
    output logic                     full,
    input  logic                     opcode,
    input  logic [KEY_W-1:0]         key,
    input  logic signed [WORD_W-1:0] value,
    // command queue side
    output logic                     cmd_push,
    output cmd_t                     cmd_data,
    input  logic                     cmdq_full,
    input  back_status_t             back_status
);

    logic [LIMIT_W-1:0] key_limit_reg;
    logic               drop_reg;
    logic               drop_next;
    logic               accept;
    logic               ok;
    op_t                op;

    assign cfg_ready = 1'b1;

    // no transfer while the table is cleared or the queue has no room
    assign full   = back_status.clearing | cmdq_full;
    assign accept = push & ~full;

    // range check against key_limit and the table size
    assign op = op_t'(opcode);
    assign ok = (LIMIT_W'(key) < key_limit_reg) && (32'(key) < 32'(NUM_KEYS));

    assign drop_next = drop_reg | ~ok;

    // out-of-range accumulates stop here
    assign cmd_push         = accept & ((op == OP_READ) | ok);
    assign cmd_data.op      = op;
    assign cmd_data.ok      = ok;
    assign cmd_data.idx     = IDX_W'(key);
    assign cmd_data.value   = value;
    assign cmd_data.dropped = drop_next;

    // configuration and sticky flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_limit_reg <= LIMIT_RESET;
            drop_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_limit_reg <= cfg_data;
            end
            if (accept)
            begin
                drop_reg <= drop_next;
            end
        end
    end

endmodule

[rtl/core/ksca_cmd_queue.sv]
// ----------------------------------------------------------------------------
// ksca_cmd_queue: short command queue between front and back
// Lets the front keep taking items while the back works on older ones.
// ----------------------------------------------------------------------------
module ksca_cmd_queue
    import ksca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic empty,
    output cmd_t head
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_PTR_W:0]   fill_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign full  = (fill_reg == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign empty = (fill_reg == '0);
    assign do_wr = wr_en & ~full;
    assign do_rd = rd_en & ~empty;
    assign head  = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH-1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH-1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/ksca_back.sv]
// ----------------------------------------------------------------------------
// ksca_back: table and update sequencer of the aggregate unit
// Clears the sum/count table after reset, then reads, updates or reports keys.
// ----------------------------------------------------------------------------
module ksca_back
    import ksca_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // command queue side
    input  logic         cmdq_empty,
    input  cmd_t         cmd_head,
    output logic         cmd_pop,
    // result queue side
    input  logic         resq_full,
    output logic         res_push,
    output res_t         res_data,
    // status to the front
    output back_status_t back_status
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] count;
    } entry_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] clr_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;

    entry_t           table_mem [NUM_KEYS];
    entry_t           rdata_reg;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    assign back_status.clearing = (state_reg == S_CLEAR);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        cmd_pop    = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = clr_reg;
        wr_data    = '0;
        res_push   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(NUM_KEYS-1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!cmdq_empty)
                begin
                    cmd_pop    = 1'b1;
                    rd_en      = 1'b1;
                    cmd_next   = cmd_head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg.op == OP_ACCUM)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = cmd_reg.idx;
                    wr_data.sum   = rdata_reg.sum + WORD_W'(cmd_reg.value);
                    wr_data.count = rdata_reg.count + 1'b1;
                    state_next    = S_IDLE;
                end
                else if (!resq_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result of a read command; out-of-range keys report zero
    always_comb
    begin
        res_data.dropped = cmd_reg.dropped;
        if (cmd_reg.ok)
        begin
            res_data.sum     = rdata_reg.sum;
            res_data.count   = rdata_reg.count;
            res_data.present = (rdata_reg.count != '0);
        end
        else
        begin
            res_data.sum     = '0;
            res_data.count   = '0;
            res_data.present = 1'b0;
        end
    end

    // state and clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // command held for the update cycle
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // sum/count table, one read and one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= table_mem[cmd_head.idx];
        end
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

endmodule

[rtl/core/ksca_result_queue.sv]
// ----------------------------------------------------------------------------
// ksca_result_queue: output queue of the aggregate unit
// Holds finished results until they are popped, decoupling the consumer.
// ----------------------------------------------------------------------------
module ksca_result_queue
    import ksca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  res_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic empty,
    output res_t head
);

    res_t                  slot_reg [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] wr_ptr_reg;
    logic [RESQ_PTR_W-1:0] rd_ptr_reg;
    logic [RESQ_PTR_W:0]   fill_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign full  = (fill_reg == (RESQ_PTR_W+1)'(RESQ_DEPTH));
    assign empty = (fill_reg == '0);
    assign do_wr = wr_en & ~full;
    assign do_rd = rd_en & ~empty;
    assign head  = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == RESQ_PTR_W'(RESQ_DEPTH-1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == RESQ_PTR_W'(RESQ_DEPTH-1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/keyed_sum_count_aggregate_unit.sv]
// ----------------------------------------------------------------------------
// keyed_sum_count_aggregate_unit: group-by sum and count aggregation engine
// Accumulates signed values per key and answers key reads with sum and count.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  --------  ----------------------  --------------------------------------
//  input     push / full             opcode, key, value
//  result    empty / pop             sum, count, present, dropped
//  config    cfg_valid / cfg_ready   cfg_data (key_limit, 13 bits)
//
//  The back end handles each queued command as a table read in IDLE, then an
//  update or report in EXEC, and takes no new command before that is done; an
//  out-of-range accumulate is taken by the front and never reaches the back.
//  After reset the table is cleared with full held high; configuration
//  transfers are taken throughout. A read result passes the command queue,
//  the table read and the report into the result queue; holding pop low
//  stalls the back only on reads, once the result queue is full.
//
// ----------------------------------------------------------------------------
module keyed_sum_count_aggregate_unit
    import ksca_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [LIMIT_W-1:0]       cfg_data,
    // input items
    input  logic                     push,
    output logic                     full,
    input  logic                     opcode,
    input  logic [KEY_W-1:0]         key,
    input  logic signed [WORD_W-1:0] value,
    // result items
    output logic                     empty,
    input  logic                     pop,
    output logic signed [WORD_W-1:0] sum,
    output logic [WORD_W-1:0]        count,
    output logic                     present,
    output logic                     dropped
);

    logic         cmd_push;
    cmd_t         cmd_data;
    logic         cmdq_full;
    logic         cmdq_empty;
    cmd_t         cmd_head;
    logic         cmd_pop;
    logic         resq_full;
    logic         res_push;
    res_t         res_data;
    res_t         res_head;
    back_status_t back_status;

    // front: configuration, range check, drop flag
    ksca_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .key         (key),
        .value       (value),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_data),
        .cmdq_full   (cmdq_full),
        .back_status (back_status)
    );

    // command queue between front and back
    ksca_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_data),
        .full    (cmdq_full),
        .rd_en   (cmd_pop),
        .empty   (cmdq_empty),
        .head    (cmd_head)
    );

    // back: table clear, update and report
    ksca_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmdq_empty  (cmdq_empty),
        .cmd_head    (cmd_head),
        .cmd_pop     (cmd_pop),
        .resq_full   (resq_full),
        .res_push    (res_push),
        .res_data    (res_data),
        .back_status (back_status)
    );

    // result queue toward the consumer
    ksca_result_queue u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (resq_full),
        .rd_en   (pop),
        .empty   (empty),
        .head    (res_head)
    );

    assign sum     = res_head.sum;
    assign count   = res_head.count;
    assign present = res_head.present;
    assign dropped = res_head.dropped;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of keyed_sum_count_aggregate_unit
// Drives accumulate and read items through the push/full queue port, keeps
// its own per-key sum/count table and drop flag, and compares every popped
// result field by field. Covers the cleared table after reset, signed wrap of
// the sums, the key limit at zero, one, oversized and full range, and random
// traffic under several sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb
    import ksca_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 190;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [LIMIT_W-1:0]       cfg_data;
    logic                     push;
    logic                     full;
    logic                     opcode;
    logic [KEY_W-1:0]         key;
    logic signed [WORD_W-1:0] value;
    logic                     empty;
    logic                     pop;
    logic signed [WORD_W-1:0] sum;
    logic [WORD_W-1:0]        count;
    logic                     present;
    logic                     dropped;

    // predicted table, drop flag and key limit
    logic [WORD_W-1:0]  sum_table   [NUM_KEYS];
    logic [WORD_W-1:0]  count_table [NUM_KEYS];
    logic               drop_seen;
    logic [LIMIT_W-1:0] key_limit_q;
    res_t               expected_totals [$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int errors        = 0;
    int items_sent    = 0;
    int reads_checked = 0;
    int cfg_writes    = 0;
    int cycle_count   = 0;

    keyed_sum_count_aggregate_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .key       (key),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .sum       (sum),
        .count     (count),
        .present   (present),
        .dropped   (dropped)
    );

    // clock, 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_totals.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    // limit above the table size acts as the table size
    function automatic bit key_in_range(input logic [KEY_W-1:0] k);
        int lim;
        lim = (int'(key_limit_q) > NUM_KEYS) ? NUM_KEYS : int'(key_limit_q);
        return int'(k) < lim;
    endfunction

    // apply one accepted item to the predicted table
    function automatic void aggregate_item(input op_t op, input logic [KEY_W-1:0] k,
                                           input logic [WORD_W-1:0] v);
        res_t totals;
        bit   ok;
        ok = key_in_range(k);
        if (!ok)
            drop_seen = 1'b1;
        if (op == OP_ACCUM)
        begin
            if (ok)
            begin
                sum_table[k]   = sum_table[k] + v;
                count_table[k] = count_table[k] + 1;
            end
        end
        else
        begin
            totals.sum     = ok ? sum_table[k] : '0;
            totals.count   = ok ? count_table[k] : '0;
            totals.present = ok && (count_table[k] != 0);
            totals.dropped = drop_seen;
            expected_totals.push_back(totals);
        end
    endfunction

    // input transfers feed the table, result transfers are checked
    always @(posedge clk)
    begin : monitor
        res_t want;
        if (rst_n && push && !full)
        begin
            aggregate_item(op_t'(opcode), key, value);
            items_sent++;
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_totals.size() == 0)
            begin
                $display("%0t: unexpected result, actual sum %0d count %0d",
                         $time, sum, count);
                errors++;
            end
            else
            begin
                want = expected_totals.pop_front();
                reads_checked++;
                if (sum !== want.sum)
                begin
                    $display("%0t: sum mismatch, expected %0d, actual %0d",
                             $time, want.sum, sum);
                    errors++;
                end
                if (count !== want.count)
                begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, want.count, count);
                    errors++;
                end
                if (present !== want.present)
                begin
                    $display("%0t: present mismatch, expected %0b, actual %0b",
                             $time, want.present, present);
                    errors++;
                end
                if (dropped !== want.dropped)
                begin
                    $display("%0t: dropped mismatch, expected %0b, actual %0b",
                             $time, want.dropped, dropped);
                    errors++;
                end
            end
        end
    end

    // one item transfer, push stays high afterwards
    task automatic send_item(input op_t op, input logic [KEY_W-1:0] k,
                             input logic [WORD_W-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push   <= 1'b1;
        opcode <= op;
        key    <= k;
        value  <= v;
        do
            @(posedge clk);
        while (full);
    endtask

    // stop sending and let every result and queued accumulate drain
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // key limit write, only with the unit idle
    task automatic write_key_limit(input logic [LIMIT_W-1:0] lim);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        key_limit_q = lim;
        cfg_writes++;
    endtask

    // fresh table reads all zero with no drop yet
    task automatic test_cleared_table();
        send_item(OP_READ, '0, '0);
        send_item(OP_READ, '1, '0);
    endtask

    // signed wrap of the sums at both table ends, back-to-back same key
    task automatic test_sum_wrap();
        send_item(OP_ACCUM, '0, 32'h7fff_ffff);
        send_item(OP_ACCUM, '0, 32'h0000_0001);
        send_item(OP_READ,  '0, '0);
        send_item(OP_ACCUM, '1, 32'h8000_0000);
        send_item(OP_ACCUM, '1, 32'hffff_ffff);
        send_item(OP_READ,  '1, 32'hffff_ffff);
        send_item(OP_ACCUM, '0, '0);
        send_item(OP_READ,  '0, '0);
    endtask

    // limit of one, zero and oversized; out-of-range drops
    task automatic test_key_limit_cases();
        write_key_limit(LIMIT_W'(1));
        send_item(OP_ACCUM, KEY_W'(0), 32'd5);
        send_item(OP_ACCUM, KEY_W'(1), 32'd9);
        send_item(OP_READ,  KEY_W'(1), '0);
        send_item(OP_READ,  KEY_W'(0), '0);
        write_key_limit('0);
        send_item(OP_READ,  KEY_W'(0), '0);
        send_item(OP_ACCUM, KEY_W'(0), -32'sd7);
        write_key_limit(LIMIT_MAX);
        send_item(OP_ACCUM, '1, 32'd3);
        send_item(OP_READ,  '1, '0);
    endtask

    // one random item, keys biased toward a small hot set and the limit edge
    task automatic send_random_item();
        int                eff;
        int                pick;
        op_t               op;
        logic [KEY_W-1:0]  k;
        logic [WORD_W-1:0] v;
        eff  = (int'(key_limit_q) > NUM_KEYS) ? NUM_KEYS : int'(key_limit_q);
        op   = ($urandom_range(99) < 40) ? OP_READ : OP_ACCUM;
        pick = $urandom_range(9);
        if (pick < 4 && eff > 0)
            k = KEY_W'($urandom_range((eff - 1 < 7) ? eff - 1 : 7));
        else if (pick < 7 && eff > 0)
            k = KEY_W'($urandom_range(eff - 1));
        else if (pick == 7)
            k = KEY_W'(eff - 1 + $urandom_range(1));
        else
            k = KEY_W'($urandom);
        case ($urandom_range(9))
            0:       v = 32'h7fff_ffff;
            1:       v = 32'h8000_0000;
            2:       v = 32'hffff_ffff;
            3:       v = 32'h0000_0001;
            default: v = $urandom;
        endcase
        send_item(op, k, v);
    endtask

    // random traffic over four idle/stall mixes and key limits
    task automatic test_random_traffic();
        int                 idle_plan  [4] = '{0, 73, 0, 23};
        int                 stall_plan [4] = '{0, 0, 73, 23};
        logic [LIMIT_W-1:0] limit_plan [4];
        limit_plan = '{LIMIT_RESET, LIMIT_W'(37), LIMIT_MAX,
                       LIMIT_W'($urandom_range(2, 4095))};
        for (int p = 0; p < 4; p++)
        begin
            write_key_limit(limit_plan[p]);
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            repeat (RANDOM_ITEMS) send_random_item();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= LIMIT_RESET;
        push      <= 1'b0;
        opcode    <= OP_ACCUM;
        key       <= '0;
        value     <= '0;
        pop       <= 1'b0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            sum_table[i]   = '0;
            count_table[i] = '0;
        end
        drop_seen   = 1'b0;
        key_limit_q = LIMIT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_table();
        test_sum_wrap();
        test_key_limit_cases();
        test_random_traffic();
        wait_drained();

        $display("sent %0d items, checked %0d read results, %0d key limit writes",
                 items_sent, reads_checked, cfg_writes);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ksca_pkg.sv
rtl/core/ksca_front.sv
rtl/core/ksca_cmd_queue.sv
rtl/core/ksca_back.sv
rtl/core/ksca_result_queue.sv
rtl/core/keyed_sum_count_aggregate_unit.sv
tb/sv/tb.sv
